// ===== rtl/escpd_pkg.sv =====
// shared types and constants for the escaped packet deframer
`default_nettype none

package escpd_pkg;

  localparam int unsigned MAX_PACKET = 4096;
  localparam int unsigned LEN_W      = 13;
  localparam int unsigned CFG_IDX_W  = 3;

  // input item kinds
  localparam logic [1:0] KIND_RAW    = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_FLUSH  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ESC_SYM  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_PFX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_XON_SYM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_XOFF_SYM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_SYM = 3'd4;

  // escape codes carried in bits 2:0 of a valid code byte
  localparam logic [2:0] EC_SOP  = 3'd0;
  localparam logic [2:0] EC_EOP  = 3'd1;
  localparam logic [2:0] EC_NAK  = 3'd2;
  localparam logic [2:0] EC_ATTN = 3'd3;
  localparam logic [2:0] EC_XON  = 3'd4;
  localparam logic [2:0] EC_XOFF = 3'd5;
  localparam logic [2:0] EC_FILL = 3'd6;
  localparam logic [2:0] EC_ESC  = 3'd7;

  // comma codes reported per result
  localparam logic [2:0] CM_NONE = 3'd0;
  localparam logic [2:0] CM_SOP  = 3'd1;
  localparam logic [2:0] CM_EOP  = 3'd2;
  localparam logic [2:0] CM_NAK  = 3'd3;
  localparam logic [2:0] CM_ATTN = 3'd4;
  localparam logic [2:0] CM_DATA = 3'd5;
  localparam logic [2:0] CM_CLOB = 3'd6;

  // receive states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FILL  = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;
  localparam logic [1:0] ST_ERROR = 2'd3;

  // packet states
  localparam logic [1:0] PS_PENDING = 2'd0;
  localparam logic [1:0] PS_RESP    = 2'd1;
  localparam logic [1:0] PS_ATTN    = 2'd2;
  localparam logic [1:0] PS_ERROR   = 2'd3;

  // frame flag bit positions
  localparam int unsigned FL_SOP   = 0;
  localparam int unsigned FL_ATTN  = 1;
  localparam int unsigned FL_EOP   = 2;
  localparam int unsigned FL_NAK   = 3;
  localparam int unsigned FL_FRAME = 4;
  localparam int unsigned FL_CLOB  = 5;

  localparam logic [7:0] PFX_MASK = 8'hC0;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] raw_byte;
  } in_item_t;

  typedef struct packed {
    logic             consumed;
    logic             data_valid;
    logic [7:0]       data_byte;
    logic [1:0]       drop_count;
    logic [7:0]       drop_byte;
    logic [2:0]       comma_code;
    logic [1:0]       packet_state;
    logic [5:0]       flag_bits;
    logic             nak_valid;
    logic [LEN_W-1:0] nak_position;
    logic [LEN_W-1:0] packet_length;
  } out_item_t;

  typedef struct packed {
    logic       clobbered;
    logic [2:0] code;
  } esc_dec_t;

endpackage

`default_nettype wire

// ===== rtl/escaped_packet_deframer_core.sv =====
// escaped packet deframer top level: framing state, unescaping and result register
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall  | in_item (kind, raw_byte)
//  out_    | output    | out_valid / out_stall| out_item (one result per input)
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one item per cycle while in_stall is low; each result is registered and appears in the cycle after its item is taken
// the framing state updates in the accepting cycle, so the next item sees it
// in_stall rises only while a result is held and out_stall is high
// synchronous active-low reset: idle, no escape pending, flags and counts zero,
// registers back to their defaults; cfg_ready is always high
`default_nettype none

module escaped_packet_deframer_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  escpd_pkg::in_item_t              in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output escpd_pkg::out_item_t             out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [escpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                       cfg_data
);
  import escpd_pkg::*;

  logic [7:0] esc_sym_r, esc_pfx_r, xon_sym_r, xoff_sym_r, fill_sym_r;

  logic [1:0]       state_r, state_nxt;
  logic             esc_pend_r, esc_pend_nxt;
  logic [5:0]       flags_r, flags_nxt;
  logic             nak_rec_r, nak_rec_nxt;
  logic [LEN_W-1:0] nak_at_r, nak_at_nxt;
  logic [LEN_W-1:0] byte_cnt_r, byte_cnt_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;

  logic     in_acc;
  esc_dec_t dec;

  logic       consumed, dvalid, active;
  logic [7:0] dbyte, dropb;
  logic [1:0] dcount;
  logic [2:0] comma;
  logic [1:0] pstate;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  escpd_code_dec u_dec (
    .code_byte     (in_item.raw_byte),
    .escape_prefix (esc_pfx_r),
    .dec           (dec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_sym_r  <= 8'd202;
      esc_pfx_r  <= 8'd64;
      xon_sym_r  <= 8'd17;
      xoff_sym_r <= 8'd19;
      fill_sym_r <= 8'd213;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ESC_SYM:  esc_sym_r  <= cfg_data;
        REG_ESC_PFX:  esc_pfx_r  <= cfg_data;
        REG_XON_SYM:  xon_sym_r  <= cfg_data;
        REG_XOFF_SYM: xoff_sym_r <= cfg_data;
        REG_FILL_SYM: fill_sym_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt    = state_r;
    esc_pend_nxt = esc_pend_r;
    flags_nxt    = flags_r;
    nak_rec_nxt  = nak_rec_r;
    nak_at_nxt   = nak_at_r;
    byte_cnt_nxt = byte_cnt_r;
    consumed     = 1'b0;
    dvalid       = 1'b0;
    dbyte        = 8'd0;
    dcount       = 2'd0;
    dropb        = 8'd0;
    comma        = CM_NONE;
    active       = (state_r == ST_IDLE) || (state_r == ST_FILL);

    case (in_item.kind)
      KIND_ACCEPT: begin
        flags_nxt    = 6'd0;
        state_nxt    = ST_IDLE;
        nak_rec_nxt  = 1'b0;
        nak_at_nxt   = '0;
        byte_cnt_nxt = '0;
      end
      KIND_FLUSH: begin
        esc_pend_nxt = 1'b0;
      end
      KIND_RAW: begin
        if (active) begin
          consumed = 1'b1;
          if (esc_pend_r) begin
            esc_pend_nxt = 1'b0;
            if (dec.clobbered) begin
              comma = CM_CLOB;
            end else begin
              case (dec.code)
                EC_SOP:  comma = CM_SOP;
                EC_EOP:  comma = CM_EOP;
                EC_NAK:  comma = CM_NAK;
                EC_ATTN: comma = CM_ATTN;
                default: comma = CM_DATA;
              endcase
            end
            if (state_r == ST_IDLE) begin
              if (!dec.clobbered && dec.code == EC_SOP) begin
                flags_nxt[FL_SOP] = 1'b1;
                state_nxt         = ST_FILL;
              end else if (!dec.clobbered && dec.code == EC_ATTN) begin
                flags_nxt[FL_ATTN] = 1'b1;
                state_nxt          = ST_FILL;
              end else begin
                dcount = 2'd2;
                dropb  = in_item.raw_byte;
              end
            end else if (dec.clobbered) begin
              flags_nxt[FL_CLOB] = 1'b1;
              state_nxt          = ST_ERROR;
            end else begin
              case (dec.code)
                EC_EOP: begin
                  flags_nxt[FL_EOP] = 1'b1;
                  state_nxt         = ST_DONE;
                end
                EC_NAK: begin
                  // second nak or nak inside an attention packet is a framing fault
                  if (flags_r[FL_ATTN] || flags_r[FL_NAK]) begin
                    flags_nxt[FL_FRAME] = 1'b1;
                    state_nxt           = ST_ERROR;
                  end else begin
                    flags_nxt[FL_NAK] = 1'b1;
                    nak_rec_nxt       = 1'b1;
                    nak_at_nxt        = byte_cnt_r;
                  end
                end
                EC_XON: begin
                  dvalid = 1'b1;
                  dbyte  = xon_sym_r;
                end
                EC_XOFF: begin
                  dvalid = 1'b1;
                  dbyte  = xoff_sym_r;
                end
                EC_FILL: begin
                  dvalid = 1'b1;
                  dbyte  = fill_sym_r;
                end
                EC_ESC: begin
                  dvalid = 1'b1;
                  dbyte  = esc_sym_r;
                end
                default: begin
                  // stray sop or attn inside a packet
                  flags_nxt[FL_FRAME] = 1'b1;
                  state_nxt           = ST_ERROR;
                end
              endcase
            end
          end else if (in_item.raw_byte == esc_sym_r) begin
            esc_pend_nxt = 1'b1;
          end else if (state_r == ST_IDLE) begin
            dcount = 2'd1;
            dropb  = in_item.raw_byte;
          end else begin
            dvalid = 1'b1;
            dbyte  = in_item.raw_byte;
          end
          if (dvalid && byte_cnt_r < LEN_W'(MAX_PACKET)) begin
            byte_cnt_nxt = byte_cnt_r + LEN_W'(1);
          end
        end
      end
      default: ;
    endcase

    if (state_nxt == ST_IDLE || state_nxt == ST_FILL) begin
      pstate = PS_PENDING;
    end else if (state_nxt == ST_DONE) begin
      pstate = flags_nxt[FL_SOP] ? PS_RESP : PS_ATTN;
    end else begin
      pstate = PS_ERROR;
    end

    out_nxt.consumed      = consumed;
    out_nxt.data_valid    = dvalid;
    out_nxt.data_byte     = dbyte;
    out_nxt.drop_count    = dcount;
    out_nxt.drop_byte     = dropb;
    out_nxt.comma_code    = comma;
    out_nxt.packet_state  = pstate;
    out_nxt.flag_bits     = flags_nxt;
    out_nxt.nak_valid     = nak_rec_nxt;
    out_nxt.nak_position  = nak_at_nxt;
    out_nxt.packet_length = byte_cnt_nxt;

    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      esc_pend_r  <= 1'b0;
      flags_r     <= 6'd0;
      nak_rec_r   <= 1'b0;
      nak_at_r    <= '0;
      byte_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        state_r    <= state_nxt;
        esc_pend_r <= esc_pend_nxt;
        flags_r    <= flags_nxt;
        nak_rec_r  <= nak_rec_nxt;
        nak_at_r   <= nak_at_nxt;
        byte_cnt_r <= byte_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= out_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_accept_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_item.kind == KIND_ACCEPT) |=>
      (state_r == ST_IDLE && byte_cnt_r == '0 && !nak_rec_r))
    else $error("accept item did not rearm the deframer");

  a_data_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.data_valid) |-> (out_r.drop_count == 2'd0 && out_r.consumed))
    else $error("data byte reported together with a drop");

  a_nak_flag_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.nak_valid == out_r.flag_bits[FL_NAK]))
    else $error("nak record and nak flag disagree");

  a_length_limit: assert property (@(posedge clk) disable iff (!rst_n)
    byte_cnt_r <= LEN_W'(MAX_PACKET))
    else $error("packet length beyond limit");
`endif

endmodule

`default_nettype wire

// ===== rtl/escpd_code_dec.sv =====
// escape code byte checker and decoder
`default_nettype none

module escpd_code_dec (
  input  logic [7:0]          code_byte,
  input  logic [7:0]          escape_prefix,
  output escpd_pkg::esc_dec_t dec
);
  import escpd_pkg::*;

  logic pfx_ok;
  logic chk_ok;

  assign pfx_ok = (code_byte & PFX_MASK) == escape_prefix;
  // bits 5:3 carry the complement of the code
  assign chk_ok = (~code_byte[5:3]) == code_byte[2:0];

  assign dec.clobbered = !(pfx_ok && chk_ok);
  assign dec.code      = code_byte[2:0];

endmodule

`default_nettype wire

// ===== dv/escaped_packet_deframer_core_tb.sv =====
// self-checking bench for the packet deframer: directed frames, random framed traffic, register sweeps
module escaped_packet_deframer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import escpd_pkg::*;

  localparam logic [1:0] KIND_NOP    = 2'd3;
  localparam int         HOLD_CYCLES = 400;
  localparam int         IDLE_LIMIT  = 3000;
  localparam int         RAND_ITEMS  = 200;
  localparam int         MAX_REPORTS = 100;

  typedef struct {
    in_item_t  item;
    bit        fixed;
    out_item_t want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  // deframer shadow: registers and framing state
  logic [7:0]       r_esc, r_pfx, r_xon, r_xoff, r_fill;
  logic [1:0]       rx_state;
  logic             esc_pend;
  logic [5:0]       fr_flags;
  logic             nak_rec;
  logic [LEN_W-1:0] nak_at;
  logic [LEN_W-1:0] pkt_len;

  out_item_t deframed_q[$];
  in_item_t  link_q[$];
  dir_row_t  dir_tbl[$];

  int mismatches   = 0;
  int results_seen = 0;
  int items_sent   = 0;
  int cfg_writes   = 0;
  int burst_left   = 0;
  int idle_cycles  = 0;

  escaped_packet_deframer_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic reset_shadow();
    r_esc = 8'd202; r_pfx = 8'd64; r_xon = 8'd17; r_xoff = 8'd19; r_fill = 8'd213;
    rx_state = ST_IDLE; esc_pend = 1'b0; fr_flags = '0;
    nak_rec = 1'b0; nak_at = '0; pkt_len = '0;
  endtask

  function automatic out_item_t deframe_step(input in_item_t it);
    out_item_t  r;
    logic [2:0] ec;
    logic       bad;
    r = '0;
    if (it.kind == KIND_ACCEPT) begin
      fr_flags = '0; rx_state = ST_IDLE; nak_rec = 1'b0; nak_at = '0; pkt_len = '0;
    end else if (it.kind == KIND_FLUSH) begin
      esc_pend = 1'b0;
    end else if (it.kind == KIND_RAW && (rx_state == ST_IDLE || rx_state == ST_FILL)) begin
      r.consumed = 1'b1;
      if (esc_pend) begin
        esc_pend = 1'b0;
        ec  = it.raw_byte[2:0];
        bad = ((it.raw_byte & PFX_MASK) != r_pfx) || ((it.raw_byte[5:3] ^ ec) != 3'b111);
        if (bad) r.comma_code = CM_CLOB;
        else begin
          case (ec)
            EC_SOP:  r.comma_code = CM_SOP;
            EC_EOP:  r.comma_code = CM_EOP;
            EC_NAK:  r.comma_code = CM_NAK;
            EC_ATTN: r.comma_code = CM_ATTN;
            default: r.comma_code = CM_DATA;
          endcase
        end
        if (rx_state == ST_IDLE) begin
          if (!bad && ec == EC_SOP) begin
            fr_flags[FL_SOP] = 1'b1; rx_state = ST_FILL;
          end else if (!bad && ec == EC_ATTN) begin
            fr_flags[FL_ATTN] = 1'b1; rx_state = ST_FILL;
          end else begin
            // idle escape that does not open a frame: both bytes go away
            r.drop_count = 2'd2; r.drop_byte = it.raw_byte;
          end
        end else if (bad) begin
          fr_flags[FL_CLOB] = 1'b1; rx_state = ST_ERROR;
        end else begin
          case (ec)
            EC_EOP: begin
              fr_flags[FL_EOP] = 1'b1; rx_state = ST_DONE;
            end
            EC_NAK: begin
              if (fr_flags[FL_ATTN] || fr_flags[FL_NAK]) begin
                fr_flags[FL_FRAME] = 1'b1; rx_state = ST_ERROR;
              end else begin
                fr_flags[FL_NAK] = 1'b1; nak_rec = 1'b1; nak_at = pkt_len;
              end
            end
            EC_XON: begin
              r.data_valid = 1'b1; r.data_byte = r_xon;
            end
            EC_XOFF: begin
              r.data_valid = 1'b1; r.data_byte = r_xoff;
            end
            EC_FILL: begin
              r.data_valid = 1'b1; r.data_byte = r_fill;
            end
            EC_ESC: begin
              r.data_valid = 1'b1; r.data_byte = r_esc;
            end
            default: begin
              // start code inside a frame
              fr_flags[FL_FRAME] = 1'b1; rx_state = ST_ERROR;
            end
          endcase
        end
      end else if (it.raw_byte == r_esc) begin
        esc_pend = 1'b1;
      end else if (rx_state == ST_IDLE) begin
        r.drop_count = 2'd1; r.drop_byte = it.raw_byte;
      end else begin
        r.data_valid = 1'b1; r.data_byte = it.raw_byte;
      end
      if (r.data_valid && pkt_len < LEN_W'(MAX_PACKET)) pkt_len++;
    end
    case (rx_state)
      ST_DONE:  r.packet_state = fr_flags[FL_SOP] ? PS_RESP : PS_ATTN;
      ST_ERROR: r.packet_state = PS_ERROR;
      default:  r.packet_state = PS_PENDING;
    endcase
    r.flag_bits     = fr_flags;
    r.nak_valid     = nak_rec;
    r.nak_position  = nak_at;
    r.packet_length = pkt_len;
    return r;
  endfunction

  function automatic in_item_t raw_item(input logic [7:0] b);
    in_item_t it;
    it.kind     = KIND_RAW;
    it.raw_byte = b;
    return it;
  endfunction

  // raw byte is ignored for these kinds, so it is randomized
  function automatic in_item_t ctl_item(input logic [1:0] k);
    in_item_t it;
    it.kind     = k;
    it.raw_byte = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic logic [7:0] code_byte(input logic [2:0] ec);
    return (r_pfx & PFX_MASK) | {2'b00, ~ec, ec};
  endfunction

  function automatic out_item_t plain_out(input logic c, input logic [1:0] n,
                                          input logic [7:0] b);
    out_item_t r;
    r            = '0;
    r.consumed   = c;
    r.drop_count = n;
    r.drop_byte  = b;
    return r;
  endfunction

  function automatic void queue_link(input in_item_t it);
    link_q = {link_q, it};
  endfunction

  function automatic void push_esc(input logic [2:0] ec);
    queue_link(raw_item(r_esc));
    queue_link(raw_item(code_byte(ec)));
  endfunction

  function automatic void push_data(input logic [7:0] b);
    if (b == r_esc) push_esc(EC_ESC);
    else queue_link(raw_item(b));
  endfunction

  function automatic void gen_packet();
    int len;
    int sel;
    repeat ($urandom_range(0, 2)) queue_link(raw_item(8'($urandom_range(0, 255))));
    push_esc(($urandom_range(0, 3) == 0) ? EC_ATTN : EC_SOP);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
    repeat (len) begin
      sel = $urandom_range(0, 11);
      if (sel < 7) push_data(8'($urandom_range(0, 255)));
      else if (sel < 11) push_esc(EC_XON | 3'($urandom_range(0, 3)));
      else push_esc(EC_NAK);
    end
    sel = $urandom_range(0, 11);
    case (sel)
      0: begin
        // code byte at random, nearly always clobbered
        queue_link(raw_item(r_esc));
        queue_link(raw_item(8'($urandom_range(0, 255))));
      end
      1: push_esc(($urandom_range(0, 1) == 0) ? EC_SOP : EC_ATTN);
      2: begin
        push_esc(EC_NAK);
        push_esc(EC_NAK);
      end
      3: begin
        queue_link(raw_item(r_esc));
        queue_link(ctl_item(KIND_FLUSH));
        push_esc(EC_EOP);
      end
      4: ;
      default: push_esc(EC_EOP);
    endcase
    // bytes offered while done or in error are held
    repeat ($urandom_range(0, 2)) queue_link(raw_item(8'($urandom_range(0, 255))));
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 3)) queue_link(ctl_item(2'($urandom_range(0, 3))));
    queue_link(ctl_item(KIND_ACCEPT));
  endfunction

  task automatic offer(input in_item_t it, input bit fixed, input out_item_t want);
    out_item_t pred;
    int        gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    pred = deframe_step(it);
    if (fixed) pred = want;
    deframed_q = {deframed_q, pred};
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_link_q();
    foreach (link_q[i]) offer(link_q[i], 1'b0, '0);
    drain();
  endtask

  task automatic run_random();
    link_q.delete();
    while (link_q.size() < RAND_ITEMS) gen_packet();
    run_link_q();
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ESC_SYM:  r_esc  = val;
      REG_ESC_PFX:  r_pfx  = val;
      REG_XON_SYM:  r_xon  = val;
      REG_XOFF_SYM: r_xoff = val;
      REG_FILL_SYM: r_fill = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic load_registers(input logic [7:0] esc, input logic [7:0] pfx,
                                input logic [7:0] xon, input logic [7:0] xoff,
                                input logic [7:0] fill);
    write_reg(REG_ESC_SYM, esc);
    write_reg(REG_ESC_PFX, pfx);
    write_reg(REG_XON_SYM, xon);
    write_reg(REG_XOFF_SYM, xoff);
    write_reg(REG_FILL_SYM, fill);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_row(input in_item_t it, input bit fixed, input out_item_t want);
    dir_row_t row;
    row.item  = it;
    row.fixed = fixed;
    row.want  = want;
    dir_tbl = {dir_tbl, row};
  endfunction

  function automatic void add_pred(input in_item_t it);
    add_row(it, 1'b0, '0);
  endfunction

  function automatic void add_esc_pair(input logic [2:0] ec);
    add_pred(raw_item(r_esc));
    add_pred(raw_item(code_byte(ec)));
  endfunction

  function automatic void build_directed();
    add_row(raw_item(8'h00), 1'b1, plain_out(1'b1, 2'd1, 8'h00));
    add_row(raw_item(r_esc), 1'b1, plain_out(1'b1, 2'd0, 8'h00));
    add_pred(raw_item(code_byte(EC_XON)));       // data escape while idle is dropped
    add_esc_pair(EC_SOP);
    add_pred(raw_item(8'hFF));
    add_esc_pair(EC_XON);
    add_esc_pair(EC_XOFF);
    add_esc_pair(EC_FILL);
    add_esc_pair(EC_ESC);
    add_esc_pair(EC_NAK);
    add_esc_pair(EC_NAK);                        // second nak ends in error
    add_pred(raw_item(8'h00));                   // held while in error
    add_row(ctl_item(KIND_ACCEPT), 1'b1, plain_out(1'b0, 2'd0, 8'h00));
    add_pred(raw_item(r_esc));
    add_pred(ctl_item(KIND_FLUSH));
    add_pred(raw_item(code_byte(EC_ATTN)));      // plain byte once the escape is flushed
    add_esc_pair(EC_ATTN);
    add_pred(raw_item(r_esc));
    add_pred(ctl_item(KIND_ACCEPT));             // pending escape survives accept
    add_pred(raw_item(code_byte(EC_EOP)));
    add_pred(ctl_item(KIND_NOP));
  endfunction

  task automatic cmp_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_result(input out_item_t want, input out_item_t got);
    cmp_field("consumed",      16'(got.consumed),      16'(want.consumed));
    cmp_field("data_valid",    16'(got.data_valid),    16'(want.data_valid));
    cmp_field("data_byte",     16'(got.data_byte),     16'(want.data_byte));
    cmp_field("drop_count",    16'(got.drop_count),    16'(want.drop_count));
    cmp_field("drop_byte",     16'(got.drop_byte),     16'(want.drop_byte));
    cmp_field("comma_code",    16'(got.comma_code),    16'(want.comma_code));
    cmp_field("packet_state",  16'(got.packet_state),  16'(want.packet_state));
    cmp_field("flag_bits",     16'(got.flag_bits),     16'(want.flag_bits));
    cmp_field("nak_valid",     16'(got.nak_valid),     16'(want.nak_valid));
    cmp_field("nak_position",  16'(got.nak_position),  16'(want.nak_position));
    cmp_field("packet_length", 16'(got.packet_length), 16'(want.packet_length));
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid && !out_stall) begin
      results_seen++;
      if (deframed_q.size() == 0) begin
        mismatches++;
        $display("%0t: result transaction with none expected, actual %h", $time, out_item);
      end else begin
        check_result(deframed_q.pop_front(), out_item);
      end
    end
  end

  // receiver: stall pattern picked at random from three modes, plus one long hold
  initial begin
    int cyc;
    int stall_mode;
    bit hold_done;
    cyc        = 0;
    stall_mode = 0;
    hold_done  = 1'b0;
    out_stall  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      cyc++;
      if (!hold_done && results_seen >= 300) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (cyc % 48 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 2) == 0);
        default: out_stall <= ((cyc % 8) >= 5);
      endcase
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
    $display("escaped_packet_deframer_core_tb failed");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    reset_shadow();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    build_directed();
    foreach (dir_tbl[i]) offer(dir_tbl[i].item, dir_tbl[i].fixed, dir_tbl[i].want);
    drain();
    run_random();

    load_registers(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    run_random();
    load_registers(8'd255, 8'd192, 8'd255, 8'd255, 8'd255);
    run_random();
    // prefix with low bits set: every escape is clobbered
    load_registers(8'($urandom_range(0, 255)), 8'h41, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_random();
    load_registers(8'($urandom_range(0, 255)), {2'($urandom_range(0, 3)), 6'b0},
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
    run_random();

    repeat (4) @(posedge clk);
    $display("sent %0d input transactions, checked %0d results, %0d register writes",
             items_sent, results_seen, cfg_writes);
    $display("five register settings with random framed traffic, %0d cycle receiver hold",
             HOLD_CYCLES);
    if (mismatches == 0)
      $display("escaped_packet_deframer_core_tb passed");
    else
      $display("escaped_packet_deframer_core_tb failed");
    $finish;
  end

endmodule
